@@ hw/rtl/u8ngh_pkg.sv @@
// shared types, constants and the fnv-1a step for the utf-8 n-gram hasher
// no dependencies
package u8ngh_pkg;

  // longest n-gram in codepoints, also the number of open start slots
  localparam int MAX_NGRAM = 6;
  // codepoint completions that one input word can cause
  localparam int NEVT = 3;
  localparam int EVT_W = $clog2(NEVT + 1);
  localparam int SLOT_W = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
  localparam int CPS_W = $clog2(MAX_NGRAM + 2);
  // sort positions by start codepoint, relative to the first event
  localparam int NSTART = MAX_NGRAM + NEVT - 1;
  localparam int SIDX_W = $clog2(NSTART + 1);
  // two-entry queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  // remainder unit, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0] BOW_BYTE = 8'h3C;
  localparam logic [7:0] EOW_BYTE = 8'h3E;

  typedef enum logic [1:0] {
    REG_MIN_LEN = 2'd0,
    REG_MAX_LEN = 2'd1,
    REG_BUCKETS = 2'd2,
    REG_OFFSET  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] word_byte;
    logic       word_end;
  } in_t;

  typedef struct packed {
    logic [31:0] ngram_id;
    logic [2:0]  ngram_length;
    logic        run_last;
    logic        word_last;
  } out_t;

  typedef struct packed {
    logic [2:0]  min_len;
    logic [2:0]  max_len;
    logic [30:0] buckets;
    logic [30:0] offset;
  } cfg_t;

  // all completions of one input word: slot hashes and release masks
  typedef struct packed {
    logic [NEVT-1:0][MAX_NGRAM-1:0][31:0] hash;
    logic [NEVT-1:0][MAX_NGRAM-1:0]       mask;
    logic                                 word_end;
  } bundle_t;

  // one fnv-1a step, byte sign-extended before the xor
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h ^ {{24{b[7]}}, b};
    return t * FNV_PRIME;
  endfunction

endpackage

@@ hw/rtl/u8ngh_queue.sv @@
// two-entry queue of completion bundles between front and back
// depends on u8ngh_pkg
module u8ngh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8ngh_pkg::bundle_t wr_data,
  output logic               full,
  input  logic               pop,
  output u8ngh_pkg::bundle_t rd_data,
  output logic               empty
);
  import u8ngh_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/u8ngh_front.sv @@
// front: takes word bytes, runs the fnv slots and captures each completion
// depends on u8ngh_pkg
module u8ngh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  u8ngh_pkg::in_t     in_data,
  input  u8ngh_pkg::cfg_t    cfg,
  output u8ngh_pkg::bundle_t bnd,
  output logic               bnd_push,
  input  logic               bnd_full
);
  import u8ngh_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_BOW  = 6'b000010,
    F_BYTE = 6'b000100,
    F_END1 = 6'b001000,
    F_END2 = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t              state_r, state_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 end_r, end_nxt;
  logic                 in_word_r, in_word_nxt;
  logic [MAX_NGRAM-1:0] valid_r, valid_nxt;
  logic [CPS_W-1:0]     cps_r, cps_nxt;
  logic [EVT_W-1:0]     evt_r, evt_nxt;
  logic [31:0]          hash_r [MAX_NGRAM];
  logic [31:0]          hash_nxt [MAX_NGRAM];
  logic [31:0]          src [MAX_NGRAM];
  logic [31:0]          hres [MAX_NGRAM];
  bundle_t              bnd_r, bnd_nxt;
  logic [7:0]           cur_b;
  logic                 do_begin, do_hash;
  logic [MAX_NGRAM-1:0] rel_mid, rel_fin;
  logic [2:0]           lo_eff, hi_eff;
  logic [CPS_W-1:0]     cps_inc;

  assign in_full = (state_r != F_IDLE);
  assign bnd     = bnd_r;
  assign cps_inc = (cps_r == CPS_W'(MAX_NGRAM + 1)) ? cps_r : cps_r + 1'b1;

  // release masks: slot i holds an n-gram of i+1 codepoints
  always_comb begin
    lo_eff = (cfg.min_len == 3'd0) ? 3'd1 : cfg.min_len;
    hi_eff = (cfg.max_len > 3'(MAX_NGRAM)) ? 3'(MAX_NGRAM) : cfg.max_len;
    for (int i = 0; i < MAX_NGRAM; i++) begin
      rel_mid[i] = valid_r[i] && (3'(i + 1) >= lo_eff) && (3'(i + 1) <= hi_eff);
      rel_fin[i] = rel_mid[i] && (cps_r != CPS_W'(i + 1));
    end
  end

  // sequencer: one codepoint event per cycle, holding in F_PUSH while the queue is full
  always_comb begin
    state_nxt   = state_r;
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    in_word_nxt = in_word_r;
    valid_nxt   = valid_r;
    cps_nxt     = cps_r;
    evt_nxt     = evt_r;
    bnd_nxt     = bnd_r;
    bnd_push    = 1'b0;
    do_begin    = 1'b0;
    do_hash     = 1'b0;
    cur_b       = byte_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          byte_nxt         = in_data.word_byte;
          end_nxt          = in_data.word_end;
          evt_nxt          = '0;
          bnd_nxt.mask     = '0;
          bnd_nxt.word_end = in_data.word_end;
          state_nxt        = in_word_r ? F_BYTE : F_BOW;
        end
      end
      F_BOW: begin
        cur_b       = BOW_BYTE;
        do_begin    = 1'b1;
        do_hash     = 1'b1;
        valid_nxt   = MAX_NGRAM'(1);
        cps_nxt     = CPS_W'(1);
        in_word_nxt = 1'b1;
        state_nxt   = F_BYTE;
      end
      F_BYTE: begin
        do_hash = 1'b1;
        if (byte_r[7:6] != 2'b10) begin
          for (int i = 0; i < MAX_NGRAM; i++) begin
            bnd_nxt.hash[evt_r][i] = hash_r[i];
          end
          bnd_nxt.mask[evt_r] = rel_mid;
          evt_nxt   = evt_r + 1'b1;
          do_begin  = 1'b1;
          valid_nxt = MAX_NGRAM'(valid_r << 1) | MAX_NGRAM'(1);
          cps_nxt   = cps_inc;
        end
        state_nxt = end_r ? F_END1 : F_PUSH;
      end
      F_END1: begin
        for (int i = 0; i < MAX_NGRAM; i++) begin
          bnd_nxt.hash[evt_r][i] = hash_r[i];
        end
        bnd_nxt.mask[evt_r] = rel_mid;
        evt_nxt   = evt_r + 1'b1;
        cur_b     = EOW_BYTE;
        do_begin  = 1'b1;
        do_hash   = 1'b1;
        valid_nxt = MAX_NGRAM'(valid_r << 1) | MAX_NGRAM'(1);
        cps_nxt   = cps_inc;
        state_nxt = F_END2;
      end
      F_END2: begin
        // closing '>' completes; the whole wrapped word is dropped
        for (int i = 0; i < MAX_NGRAM; i++) begin
          bnd_nxt.hash[evt_r][i] = hash_r[i];
        end
        bnd_nxt.mask[evt_r] = rel_fin;
        valid_nxt   = '0;
        cps_nxt     = '0;
        in_word_nxt = 1'b0;
        state_nxt   = F_PUSH;
      end
      F_PUSH: begin
        if (bnd_r.mask == '0) begin
          state_nxt = F_IDLE;
        end else if (!bnd_full) begin
          bnd_push  = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // hash lanes, one per slot; a new codepoint shifts the slots up
  always_comb begin
    src[0] = do_begin ? FNV_BASIS : hash_r[0];
    for (int i = 1; i < MAX_NGRAM; i++) begin
      src[i] = do_begin ? hash_r[i-1] : hash_r[i];
    end
    for (int i = 0; i < MAX_NGRAM; i++) begin
      hres[i]     = fnv_step(src[i], cur_b);
      hash_nxt[i] = do_hash ? hres[i] : hash_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      in_word_r <= 1'b0;
      valid_r   <= '0;
      cps_r     <= '0;
      evt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      in_word_r <= in_word_nxt;
      valid_r   <= valid_nxt;
      cps_r     <= cps_nxt;
      evt_r     <= evt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    bnd_r  <= bnd_nxt;
    for (int i = 0; i < MAX_NGRAM; i++) begin
      hash_r[i] <= hash_nxt[i];
    end
  end

endmodule

@@ hw/rtl/u8ngh_mod.sv @@
// remainder unit: 32-bit hash modulo a 31-bit bucket count, one bit per cycle
// depends on u8ngh_pkg
module u8ngh_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  import u8ngh_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          q_r, q_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [30:0]          div_r, div_nxt;
  logic [31:0]          sh;

  assign done = done_r;
  assign rem  = rem_r;

  // restoring step; a zero divisor leaves the hash itself
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    sh       = {rem_r[30:0], q_r[31]};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (sh >= {1'b0, div_r}) ? sh - {1'b0, div_r} : sh;
      q_nxt   = q_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

@@ hw/rtl/u8ngh_back.sv @@
// back: walks a bundle in start then length order, reduces and emits ids
// depends on u8ngh_pkg and u8ngh_mod
module u8ngh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8ngh_pkg::bundle_t q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  u8ngh_pkg::cfg_t    cfg,
  output logic               out_empty,
  input  logic               out_pop,
  output u8ngh_pkg::out_t    out_data
);
  import u8ngh_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SCAN = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  bundle_t              cur_r, cur_nxt;
  logic [SIDX_W-1:0]    sidx_r, sidx_nxt;
  logic [EVT_W-1:0]     evt_r, evt_nxt;
  logic [EVT_W-1:0]     sel_evt_r, sel_evt_nxt;
  logic [SLOT_W-1:0]    sel_slot_r, sel_slot_nxt;
  logic [2:0]           len_r, len_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;
  logic                 mod_start, mod_done;
  logic [31:0]          mod_rem;
  logic [31:0]          mod_in;
  int                   ii;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  bundle_t              left;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // position being examined: start index then event, slot = event + MAX_NGRAM - 1 - start
  always_comb begin
    ii   = int'(evt_r) + MAX_NGRAM - 1 - int'(sidx_r);
    slot = SLOT_W'(ii);
    hit  = (ii >= 0) && (ii < MAX_NGRAM) && cur_r.mask[evt_r][slot];
    mod_in = cur_r.hash[evt_r][slot];
  end

  // scan, reduce, present
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    sidx_nxt      = sidx_r;
    evt_nxt       = evt_r;
    sel_evt_nxt   = sel_evt_r;
    sel_slot_nxt  = sel_slot_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    mod_start     = 1'b0;
    left          = cur_r;
    left.mask[sel_evt_r][sel_slot_r] = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_data;
          sidx_nxt  = '0;
          evt_nxt   = '0;
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (hit) begin
          mod_start    = 1'b1;
          sel_evt_nxt  = evt_r;
          sel_slot_nxt = slot;
          len_nxt      = 3'(ii + 1);
          state_nxt    = B_DIV;
        end else if (evt_r == EVT_W'(NEVT - 1)) begin
          evt_nxt  = '0;
          sidx_nxt = sidx_r + 1'b1;
        end else begin
          evt_nxt = evt_r + 1'b1;
        end
      end
      B_DIV: begin
        if (mod_done) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt        = 1'b1;
          out_nxt.ngram_id     = {1'b0, cfg.offset} + mod_rem;
          out_nxt.ngram_length = len_r;
          out_nxt.run_last     = (left.mask == '0);
          out_nxt.word_last    = (left.mask == '0) && cur_r.word_end;
          cur_nxt              = left;
          state_nxt            = (left.mask == '0) ? B_IDLE : B_SCAN;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  u8ngh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_in),
    .divisor  (cfg.buckets),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      sidx_r      <= '0;
      evt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sidx_r      <= sidx_nxt;
      evt_r       <= evt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    sel_evt_r  <= sel_evt_nxt;
    sel_slot_r <= sel_slot_nxt;
    len_r      <= len_nxt;
    out_r      <= out_nxt;
  end

endmodule

@@ hw/rtl/utf8_char_ngram_hasher_top.sv @@
// top level: register port, front, bundle queue and back
// depends on u8ngh_pkg, u8ngh_front, u8ngh_queue, u8ngh_back
//
// Bytes of a word go in one per push, implicitly wrapped as '<' word '>';
// each result word is an fnv-1a character n-gram id, reduced modulo
// bucket_count plus id_offset, in start then length order. Per byte the
// front takes one step per codepoint event, another for the opening '<' on
// the first byte, two more for the closing '>' on the last byte, plus the
// hand-off to the two-bundle queue and the return to idle; it takes no new
// byte until it is idle again. The back spends one cycle per examined sort
// position (up to 24 per bundle) and, for each emitted id, waits on the
// one-bit-per-cycle remainder unit. The register port sits at byte addresses
// 0, 4, 8 and 12, writes take effect immediately and should be made while
// the block is idle.
module utf8_char_ngram_hasher_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  u8ngh_pkg::in_t    in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output u8ngh_pkg::out_t   out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import u8ngh_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t ridx;
  logic     cfg_wr;
  bundle_t  f_bnd, q_bnd;
  logic     f_push, q_full, q_pop, q_empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx       = reg_idx_t'(cfg_paddr[3:2]);

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (ridx)
        REG_MIN_LEN: cfg_nxt.min_len = cfg_pwdata[2:0];
        REG_MAX_LEN: cfg_nxt.max_len = cfg_pwdata[2:0];
        REG_BUCKETS: cfg_nxt.buckets = cfg_pwdata[30:0];
        REG_OFFSET:  cfg_nxt.offset  = cfg_pwdata[30:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      REG_MIN_LEN: cfg_prdata = {29'd0, cfg_r.min_len};
      REG_MAX_LEN: cfg_prdata = {29'd0, cfg_r.max_len};
      REG_BUCKETS: cfg_prdata = {1'b0, cfg_r.buckets};
      REG_OFFSET:  cfg_prdata = {1'b0, cfg_r.offset};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len <= 3'd3;
      cfg_r.max_len <= 3'd6;
      cfg_r.buckets <= 31'd2000000;
      cfg_r.offset  <= 31'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  u8ngh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .bnd      (f_bnd),
    .bnd_push (f_push),
    .bnd_full (q_full)
  );

  u8ngh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (f_bnd),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_bnd),
    .empty   (q_empty)
  );

  u8ngh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_bnd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // end of word only on the last id of a run
  a_word_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.word_last |-> out_data.run_last)
    else $error("word_last without run_last");

  // the front is busy in the cycle after taking a byte
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("front accepted back to back");

  // emitted lengths stay in range
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.ngram_length != 3'd0) &&
                   (out_data.ngram_length <= 3'(MAX_NGRAM)))
    else $error("n-gram length out of range");

  // the queue is never pushed while full
  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full)
    else $error("bundle pushed into full queue");

endmodule
